### hw/rtl/rppu_pkg.sv
// ----------------------------------------------------------------------------
// rppu_pkg
// Shared types and constants of the relative pose projection unit.
// ----------------------------------------------------------------------------
package rppu_pkg;

   localparam int POS_FRAC_BITS_DEF  = 16;
   localparam int QUAT_FRAC_BITS_DEF = 14;

   // Radix-2 divider: one quotient bit per step over a 64-bit dividend
   localparam int DIV_STEPS = 64;
   localparam int CNT_W     = 6;

   // Configuration register indexes
   localparam logic [2:0] CSR_FOCAL_PX     = 3'd0;
   localparam logic [2:0] CSR_CENTER_U     = 3'd1;
   localparam logic [2:0] CSR_CENTER_V     = 3'd2;
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_CAM_OFF_X    = 3'd5;
   localparam logic [2:0] CSR_CAM_OFF_Y    = 3'd6;
   localparam logic [2:0] CSR_CAM_OFF_Z    = 3'd7;

   // Configuration reset values
   localparam logic [31:0] FOCAL_PX_RST     = 32'd30654051;
   localparam logic [11:0] CENTER_U_RST     = 12'd320;
   localparam logic [11:0] CENTER_V_RST     = 12'd240;
   localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;
   localparam logic [31:0] CAM_OFF_X_RST    = 32'd0;
   localparam logic [31:0] CAM_OFF_Y_RST    = 32'd0;
   localparam logic [31:0] CAM_OFF_Z_RST    = 32'd8520;

   // Input function codes
   localparam logic FUNC_OBSERVER = 1'b0;
   localparam logic FUNC_TARGET   = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_QMUL,
      OP_QSTORE,
      OP_ROT,
      OP_CMUL,
      OP_CACC,
      OP_CFIN,
      OP_PMUL,
      OP_DINIT,
      OP_DSTEP,
      OP_PFIN,
      OP_OUT
   } rppu_op_type;

   typedef struct packed {
      rppu_op_type      op;
      logic [1:0]       ax;   // camera axis, or pixel axis (0 = u, 1 = v)
      logic [1:0]       row;  // rotation row / difference component
      logic [CNT_W-1:0] cnt;  // quaternion product index / divider step
   } rppu_cmd_type;

   typedef struct packed {
      logic front;     // camera x of the current transaction is positive
      logic out_free;  // result register may be loaded this cycle
   } rppu_stat_type;

endpackage

### hw/rtl/rppu_ctrl.sv
// ----------------------------------------------------------------------------
// rppu_ctrl
// Sequencer: steps the shared multiplier and divider through one transaction.
// ----------------------------------------------------------------------------
module rppu_ctrl
   import rppu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_func,
   output logic          req_tready,
   input  rppu_stat_type stat,
   output rppu_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_QMUL, S_QSTORE, S_ROT, S_CMUL, S_CACC, S_CFIN,
      S_PMUL, S_DINIT, S_DSTEP, S_PFIN, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       ax_ff, ax_in;
   logic [1:0]       row_ff, row_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      ax_in    = ax_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ax_in    = '0;
               row_in   = '0;
               cnt_in   = '0;
               state_in = (req_func == FUNC_TARGET) ? S_CMUL : S_QMUL;
            end
         end
         S_QMUL:   state_in = S_QSTORE;
         S_QSTORE: begin
            if (cnt_ff == CNT_W'(8)) begin
               state_in = S_ROT;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_QMUL;
            end
         end
         S_ROT:  state_in = S_CMUL;
         S_CMUL: state_in = S_CACC;
         S_CACC: begin
            if (row_ff == 2'd2) begin
               state_in = S_CFIN;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_CMUL;
            end
         end
         S_CFIN: begin
            row_in = '0;
            if (ax_ff == 2'd2) begin
               ax_in    = '0;
               state_in = stat.front ? S_PMUL : S_OUT;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = S_CMUL;
            end
         end
         S_PMUL: begin
            cnt_in   = '0;
            state_in = S_DINIT;
         end
         S_DINIT: state_in = S_DSTEP;
         S_DSTEP: begin
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_PFIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_PFIN: begin
            if (ax_ff == 2'd0) begin
               ax_in    = 2'd1;
               state_in = S_PMUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= '0;
         row_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         row_ff   <= row_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd.ax  = ax_ff;
      cmd.row = row_ff;
      cmd.cnt = cnt_ff;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_tvalid ? OP_LOAD : OP_NONE;
         S_QMUL:   cmd.op = OP_QMUL;
         S_QSTORE: cmd.op = OP_QSTORE;
         S_ROT:    cmd.op = OP_ROT;
         S_CMUL:   cmd.op = OP_CMUL;
         S_CACC:   cmd.op = OP_CACC;
         S_CFIN:   cmd.op = OP_CFIN;
         S_PMUL:   cmd.op = OP_PMUL;
         S_DINIT:  cmd.op = OP_DINIT;
         S_DSTEP:  cmd.op = OP_DSTEP;
         S_PFIN:   cmd.op = OP_PFIN;
         S_OUT:    cmd.op = stat.out_free ? OP_OUT : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule

### hw/rtl/rppu_dpath.sv
// ----------------------------------------------------------------------------
// rppu_dpath
// Datapath: pose state, configuration, shared multiplier, serial divider
// and the result register.
// ----------------------------------------------------------------------------
module rppu_dpath
   import rppu_pkg::*;
#(
   parameter int POS_FRAC_BITS  = POS_FRAC_BITS_DEF,
   parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
)(
   input  logic          clock,
   input  logic          reset,
   input  logic [2:0]    csr_addr,
   input  logic [31:0]   csr_wdata,
   input  logic          csr_we,
   input  logic [159:0]  req_tdata,
   input  logic          req_func,
   input  rppu_cmd_type  cmd,
   output rppu_stat_type stat,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser
);

   localparam int QF = QUAT_FRAC_BITS;

   // Configuration
   logic        [31:0] focal_ff;
   logic        [11:0] cu_ff, cv_ff;
   logic        [12:0] iw_ff, ih_ff;
   logic signed [31:0] off_ff [3];

   // Pose state
   logic signed [31:0] obs_ff [3];
   logic signed [31:0] tgt_ff [3];
   logic signed [17:0] rot_ff [9];
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [31:0] qp_ff [9];

   // Arithmetic
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] prod_ff;
   logic signed [55:0] acc_ff;
   logic signed [31:0] cam_ff [3];
   logic        [63:0] dvd_ff, den_ff, quo_ff;
   logic        [64:0] rem_ff;

   // Result
   logic signed [15:0] pu_ff, pv_ff;
   logic               inu_ff, inv_ff;
   logic               rsp_valid_ff;
   logic        [127:0] rsp_data_ff;
   logic        [1:0]   rsp_user_ff;

   function automatic logic signed [17:0] rnd_sat18(input logic signed [35:0] v);
      logic signed [35:0] r;
      r = (v + (36'sd1 <<< (QF - 1))) >>> QF;
      if (r > 36'sd131071)       return 18'sd131071;
      else if (r < -36'sd131072) return -18'sd131072;
      else                       return r[17:0];
   endfunction

   function automatic logic signed [35:0] ext36(input logic signed [31:0] v);
      return {{4{v[31]}}, v};
   endfunction

   // Quaternion products: xx yy zz xy xz yz xw yw zw
   logic signed [35:0] one36;
   logic signed [17:0] rot_in [9];
   always_comb begin
      one36     = 36'sd1 <<< (2 * QF);
      rot_in[0] = rnd_sat18(one36 - ((ext36(qp_ff[1]) + ext36(qp_ff[2])) <<< 1));
      rot_in[1] = rnd_sat18((ext36(qp_ff[3]) - ext36(qp_ff[8])) <<< 1);
      rot_in[2] = rnd_sat18((ext36(qp_ff[4]) + ext36(qp_ff[7])) <<< 1);
      rot_in[3] = rnd_sat18((ext36(qp_ff[3]) + ext36(qp_ff[8])) <<< 1);
      rot_in[4] = rnd_sat18(one36 - ((ext36(qp_ff[0]) + ext36(qp_ff[2])) <<< 1));
      rot_in[5] = rnd_sat18((ext36(qp_ff[5]) - ext36(qp_ff[6])) <<< 1);
      rot_in[6] = rnd_sat18((ext36(qp_ff[4]) - ext36(qp_ff[7])) <<< 1);
      rot_in[7] = rnd_sat18((ext36(qp_ff[5]) + ext36(qp_ff[6])) <<< 1);
      rot_in[8] = rnd_sat18(one36 - ((ext36(qp_ff[0]) + ext36(qp_ff[1])) <<< 1));
   end

   // Operand selection
   logic signed [32:0] dsel;
   logic        [3:0]  ridx;
   logic signed [15:0] qa, qb;
   logic signed [31:0] psel;
   logic        [32:0] pmag;
   always_comb begin
      case (cmd.row)
         2'd0:    dsel = {tgt_ff[0][31], tgt_ff[0]} - {obs_ff[0][31], obs_ff[0]};
         2'd1:    dsel = {tgt_ff[1][31], tgt_ff[1]} - {obs_ff[1][31], obs_ff[1]};
         default: dsel = {tgt_ff[2][31], tgt_ff[2]} - {obs_ff[2][31], obs_ff[2]};
      endcase
      ridx = 4'(cmd.row) * 4'd3 + 4'(cmd.ax);
      case (cmd.cnt[3:0])
         4'd0:    begin qa = qx_ff; qb = qx_ff; end
         4'd1:    begin qa = qy_ff; qb = qy_ff; end
         4'd2:    begin qa = qz_ff; qb = qz_ff; end
         4'd3:    begin qa = qx_ff; qb = qy_ff; end
         4'd4:    begin qa = qx_ff; qb = qz_ff; end
         4'd5:    begin qa = qy_ff; qb = qz_ff; end
         4'd6:    begin qa = qx_ff; qb = qw_ff; end
         4'd7:    begin qa = qy_ff; qb = qw_ff; end
         default: begin qa = qz_ff; qb = qw_ff; end
      endcase
      psel = cmd.ax[0] ? cam_ff[2] : cam_ff[1];
      pmag = psel[31] ? (33'd0 - {1'b1, psel}) : {1'b0, psel};
      case (cmd.op)
         OP_QMUL: begin
            mul_a = {{18{qa[15]}}, qa};
            mul_b = {{18{qb[15]}}, qb};
         end
         OP_CMUL: begin
            mul_a = {dsel[32], dsel};
            mul_b = {{16{rot_ff[ridx][17]}}, rot_ff[ridx]};
         end
         default: begin
            mul_a = {1'b0, pmag};
            mul_b = {2'b00, focal_ff};
         end
      endcase
   end

   // Camera component: round, add offset, saturate
   logic signed [55:0] crnd;
   logic signed [56:0] csum;
   logic signed [31:0] cam_in;
   always_comb begin
      crnd = (acc_ff + (56'sd1 <<< (QF - 1))) >>> QF;
      csum = {crnd[55], crnd} + {{25{off_ff[cmd.ax][31]}}, off_ff[cmd.ax]};
      if (csum > 57'sh7FFFFFFF)        cam_in = 32'sh7FFFFFFF;
      else if (csum < -57'sh80000000)  cam_in = 32'sh80000000;
      else                              cam_in = csum[31:0];
   end

   // Divider step
   logic [64:0] dtry;
   logic        dge;
   always_comb begin
      dtry = {rem_ff[63:0], dvd_ff[63]};
      dge  = (dtry >= {1'b0, den_ff});
   end

   // Pixel from quotient and remainder
   logic signed [66:0] qx67, cx67, dif, pix;
   logic        [11:0] cen;
   logic        [12:0] lim;
   logic               pin;
   logic signed [15:0] pix16;
   always_comb begin
      cen  = cmd.ax[0] ? cv_ff : cu_ff;
      lim  = cmd.ax[0] ? ih_ff : iw_ff;
      qx67 = {3'b000, quo_ff};
      cx67 = {55'd0, cen};
      dif  = cx67 - qx67;
      if (psel > 32'sd0) begin
         pix = ((dif > 67'sd0) && (rem_ff != '0)) ? dif - 67'sd1 : dif;
      end else begin
         pix = qx67 + cx67;
      end
      pin = (pix >= 67'sd0) && (pix < {54'd0, lim});
      if (pix > 67'sd32767)       pix16 = 16'sd32767;
      else if (pix < -67'sd32768) pix16 = -16'sd32768;
      else                        pix16 = pix[15:0];
   end

   assign stat.front    = (cam_ff[0] > 32'sd0);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // Configuration and pose state
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff  <= FOCAL_PX_RST;
         cu_ff     <= CENTER_U_RST;
         cv_ff     <= CENTER_V_RST;
         iw_ff     <= IMAGE_WIDTH_RST;
         ih_ff     <= IMAGE_HEIGHT_RST;
         off_ff[0] <= CAM_OFF_X_RST;
         off_ff[1] <= CAM_OFF_Y_RST;
         off_ff[2] <= CAM_OFF_Z_RST;
         for (int i = 0; i < 3; i++) begin
            obs_ff[i] <= '0;
            tgt_ff[i] <= '0;
         end
         for (int i = 0; i < 9; i++) begin
            rot_ff[i] <= ((i % 4) == 0) ? (18'sd1 <<< QF) : 18'sd0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_FOCAL_PX:     focal_ff  <= csr_wdata;
               CSR_CENTER_U:     cu_ff     <= csr_wdata[11:0];
               CSR_CENTER_V:     cv_ff     <= csr_wdata[11:0];
               CSR_IMAGE_WIDTH:  iw_ff     <= csr_wdata[12:0];
               CSR_IMAGE_HEIGHT: ih_ff     <= csr_wdata[12:0];
               CSR_CAM_OFF_X:    off_ff[0] <= csr_wdata;
               CSR_CAM_OFF_Y:    off_ff[1] <= csr_wdata;
               CSR_CAM_OFF_Z:    off_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.op == OP_LOAD) begin
            if (req_func == FUNC_TARGET) begin
               tgt_ff[0] <= req_tdata[31:0];
               tgt_ff[1] <= req_tdata[63:32];
               tgt_ff[2] <= req_tdata[95:64];
            end else begin
               obs_ff[0] <= req_tdata[31:0];
               obs_ff[1] <= req_tdata[63:32];
               obs_ff[2] <= req_tdata[95:64];
            end
         end
         if (cmd.op == OP_ROT) begin
            for (int i = 0; i < 9; i++) rot_ff[i] <= rot_in[i];
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd.op)
         OP_LOAD: begin
            qw_ff  <= req_tdata[111:96];
            qx_ff  <= req_tdata[127:112];
            qy_ff  <= req_tdata[143:128];
            qz_ff  <= req_tdata[159:144];
            pu_ff  <= '0;
            pv_ff  <= '0;
            inu_ff <= 1'b0;
            inv_ff <= 1'b0;
         end
         OP_QSTORE: qp_ff[cmd.cnt[3:0]] <= prod_ff[31:0];
         OP_CACC:   acc_ff <= (cmd.row == 2'd0) ? prod_ff[55:0] : acc_ff + prod_ff[55:0];
         OP_CFIN:   cam_ff[cmd.ax] <= cam_in;
         OP_DINIT: begin
            dvd_ff <= prod_ff[63:0];
            den_ff <= {32'd0, cam_ff[0]} << POS_FRAC_BITS;
            rem_ff <= '0;
            quo_ff <= '0;
         end
         OP_DSTEP: begin
            rem_ff <= dge ? (dtry - {1'b0, den_ff}) : dtry;
            dvd_ff <= {dvd_ff[62:0], 1'b0};
            quo_ff <= {quo_ff[62:0], dge};
         end
         OP_PFIN: begin
            if (cmd.ax[0]) begin
               pv_ff  <= pix16;
               inv_ff <= pin;
            end else begin
               pu_ff  <= pix16;
               inu_ff <= pin;
            end
         end
         default: ;
      endcase
      if (cmd.op == OP_OUT) begin
         rsp_data_ff <= {cam_ff[2], cam_ff[1], cam_ff[0], pv_ff, pu_ff};
         rsp_user_ff <= {stat.front & inu_ff & inv_ff, stat.front};
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### hw/rtl/relative_pose_pinhole_projection_unit.sv
// ----------------------------------------------------------------------------
// relative_pose_pinhole_projection_unit
// Projects a target into the pinhole camera carried by an observer.
// ----------------------------------------------------------------------------
// Each request transaction loads either the observer pose (tuser 0: position
// and Q2.14 quaternion) or the target position (tuser 1), and yields exactly
// one response transaction: the target in the camera frame, the projected
// pixel and the in-front / in-image flags. One transaction is worked at a
// time. A target load computes the target in the camera frame and, when the
// point is in front of the camera, both pixel coordinates; an observer load
// first builds the rotation matrix. The work is paced by the single shared
// 34x34 multiplier and by the radix-2 divider, which resolves one quotient
// bit per step for each pixel coordinate. A finished response waits in its
// own register, so the next request is taken while it is still pending.
// Configuration writes are accepted at any time but must only be made while
// the unit is idle.
// ----------------------------------------------------------------------------
module relative_pose_pinhole_projection_unit
   import rppu_pkg::*;
#(
   parameter int POS_FRAC_BITS  = POS_FRAC_BITS_DEF,
   parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
)(
   input  logic         clock,
   input  logic         reset,
   // Configuration write port
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata,
   // Request: pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,
   // Request tuser: func
   input  logic         req_tuser,
   // Response: pixel_u, pixel_v, cam_x, cam_y, cam_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,
   // Response tuser: in_front, in_image
   output logic [1:0]   rsp_tuser
);

   rppu_cmd_type  cmd;
   rppu_stat_type stat;

   // Sequence the transaction
   rppu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Hold pose and configuration, compute and register the response
   rppu_dpath #(
      .POS_FRAC_BITS  (POS_FRAC_BITS),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .csr_we     (csr_we),
      .req_tdata  (req_tdata),
      .req_func   (req_tuser),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### hw/rtl/rppu_checker.sv
// ----------------------------------------------------------------------------
// rppu_checker
// Port-level checks of the response channel.
// ----------------------------------------------------------------------------
module rppu_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser
);

   // Stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // In image only when in front
   a_image_front: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("in_image without in_front");

   // Behind the camera: pixel fields are zero
   a_behind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0)
      else $error("pixel set for point behind camera");

   // In front means positive forward distance
   a_front_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tdata[63] && rsp_tdata[63:32] != 32'd0)
      else $error("in_front with non-positive cam_x");

   // Inside the image means non-negative pixel
   a_image_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tdata[15] && !rsp_tdata[31])
      else $error("in_image with negative pixel");

endmodule

bind relative_pose_pinhole_projection_unit rppu_checker u_rppu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
